[design/il53_pkg.sv]
// Shared types, constants and a saturation helper function for the inverse 5/3 lifting line block.
package il53_pkg;

    localparam int COEF_BITS    = 20;
    localparam int SMOOTH_BITS  = COEF_BITS + 2;
    localparam int CALC_BITS    = COEF_BITS + 4;
    localparam int LEN_BITS     = 16;
    localparam int NUM_SLOTS    = 4;
    localparam int CNT_BITS     = 3;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_BITS     = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_PARITY = 1'b1;

    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [SMOOTH_BITS-1:0] t_smooth;
    typedef logic signed [CALC_BITS-1:0]   t_calc;
    typedef logic [LEN_BITS-1:0]           t_len;
    typedef logic [CNT_BITS-1:0]           t_cnt;

    localparam t_calc C_TWO  = t_calc'(2);
    localparam t_calc SAT_HI = t_calc'((64'sd1 <<< (COEF_BITS - 1)) - 64'sd1);
    localparam t_calc SAT_LO = t_calc'(-(64'sd1 <<< (COEF_BITS - 1)));

    typedef struct packed {
        t_coef   high;
        t_coef   low;
        t_smooth smooth;
    } t_held;

    typedef struct packed {
        logic [NUM_SLOTS-1:0][COEF_BITS-1:0] samples;
        t_cnt                                count;
        logic                                last_line;
        t_held                               held;
    } t_calc_out;

    function automatic t_coef sat_coef(input t_calc v);
        t_coef r;
        if (v > SAT_HI) begin
            r = SAT_HI[COEF_BITS-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[COEF_BITS-1:0];
        end else begin
            r = v[COEF_BITS-1:0];
        end
        return r;
    endfunction

endpackage

[design/il53_calc.sv]
// Combinational lifting arithmetic for one coefficient pair: samples, count and next held values.
module il53_calc (
    input  il53_pkg::t_coef     i_low,
    input  il53_pkg::t_coef     i_high,
    input  il53_pkg::t_held     i_held,
    input  il53_pkg::t_len      i_len,
    input  logic                i_par,
    input  il53_pkg::t_len      i_pair_cnt,
    output il53_pkg::t_calc_out o_res,
    output il53_pkg::t_len      o_pair_cnt
);
    import il53_pkg::*;

    logic [LEN_BITS:0] len_eff;
    logic [LEN_BITS:0] pairs;
    logic              last;
    logic              odd_len;
    logic              first;

    always_comb begin
        t_calc s;
        t_calc d;
        t_calc hh;
        t_calc hl;
        t_calc hs;
        t_calc dl;
        t_calc dr;
        t_calc e;
        t_calc e1;
        t_calc e2;
        t_calc el;
        t_calc hs_cur;
        t_cnt  n;

        len_eff = (i_len == '0) ? (LEN_BITS+1)'(1) : {1'b0, i_len};
        pairs   = (len_eff + (LEN_BITS+1)'(1)) >> 1;
        last    = ({1'b0, i_pair_cnt} + (LEN_BITS+1)'(1)) >= pairs;
        odd_len = len_eff[0];
        first   = (i_pair_cnt == '0);

        s  = t_calc'(i_low);
        d  = t_calc'(i_high);
        hh = t_calc'(i_held.high);
        hl = t_calc'(i_held.low);
        hs = t_calc'(i_held.smooth);

        dl     = first ? d : hh;
        dr     = (last && odd_len) ? hh : d;
        e      = s - ((dl + dr + C_TWO) >>> 2);
        e1     = hl - ((hh + d + C_TWO) >>> 2);
        e2     = s - ((d + d + C_TWO) >>> 2);
        hs_cur = first ? hs : e1;
        el     = '0;

        n            = '0;
        o_res        = '0;
        o_res.held   = i_held;

        if (len_eff == (LEN_BITS+1)'(1)) begin
            o_res.samples[0] = i_par ? sat_coef(d >>> 1) : sat_coef(s);
            n = t_cnt'(1);
        end else if (!i_par) begin
            if (!first) begin
                o_res.samples[n[1:0]] = sat_coef(hh + ((hs + e) >>> 1));
                n = n + t_cnt'(1);
            end
            o_res.samples[n[1:0]] = sat_coef(e);
            n = n + t_cnt'(1);
            if (last && !odd_len) begin
                o_res.samples[n[1:0]] = sat_coef(d + e);
                n = n + t_cnt'(1);
            end
            o_res.held.high   = i_high;
            o_res.held.low    = i_low;
            o_res.held.smooth = t_smooth'(e);
        end else begin
            if (!first) begin
                el = (i_pair_cnt == t_len'(1)) ? e1 : hs;
                o_res.samples[n[1:0]] = sat_coef(hh + ((el + e1) >>> 1));
                n = n + t_cnt'(1);
                o_res.samples[n[1:0]] = sat_coef(e1);
                n = n + t_cnt'(1);
                o_res.held.smooth = t_smooth'(e1);
            end
            if (last) begin
                if (!odd_len) begin
                    el = first ? e2 : hs_cur;
                    o_res.samples[n[1:0]] = sat_coef(d + ((el + e2) >>> 1));
                    n = n + t_cnt'(1);
                    o_res.samples[n[1:0]] = sat_coef(e2);
                    n = n + t_cnt'(1);
                    o_res.held.smooth = t_smooth'(e2);
                end else begin
                    o_res.samples[n[1:0]] = sat_coef(d + hs_cur);
                    n = n + t_cnt'(1);
                end
            end
            o_res.held.high = i_high;
            o_res.held.low  = i_low;
        end

        o_res.count     = n;
        o_res.last_line = last;
        o_pair_cnt      = last ? '0 : (i_pair_cnt + t_len'(1));
    end

endmodule

[design/inverse_53_lifting_line_top.sv]
// Top level of the streaming inverse 5/3 lifting line reconstruction block.
// Usage: program line_length and start_parity through the write port while the block
// is idle; any write restarts the line. Then send one item per coefficient pair
// (low coefficient k, high coefficient k) on the input channel. Samples leave in
// line order on the output channel, one per cycle while the receiver is ready,
// with o_last_of_line on the last. An accepted item is held in the input register
// while its samples are computed; they are then loaded into the result buffer,
// which offers the first of them. An item's samples occupy the result buffer until
// the last is taken; a line of L samples comes as about L/2 items, two samples
// per item on average. The single output port is the limiting resource.
// The next item is taken while earlier samples still drain.
// When the receiver stalls the result buffer holds, the input register fills and
// o_ready falls; nothing is lost. Reset (synchronous, active low) empties both
// stages, sets line_length to 1, start_parity to 0 and clears the held values.
module inverse_53_lifting_line_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [il53_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [il53_pkg::CFG_BITS-1:0]           i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [il53_pkg::COEF_BITS-1:0]   i_low_coef,
    input  logic signed [il53_pkg::COEF_BITS-1:0]   i_high_coef,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [il53_pkg::COEF_BITS-1:0]   o_output_sample,
    output logic                                    o_last_of_line
);
    import il53_pkg::*;

    t_len  r_len;
    logic  r_par;
    t_len  r_pair_cnt;
    t_held r_held;
    logic  r_in_valid;
    t_coef r_in_low;
    t_coef r_in_high;
    logic [NUM_SLOTS-1:0][COEF_BITS-1:0] r_buf;
    t_cnt  r_cnt;
    logic  r_last_line;

    t_calc_out calc_res;
    t_len      n_pair_cnt;
    logic      pop;
    logic      advance;

    il53_calc u_calc (
        .i_low      (r_in_low),
        .i_high     (r_in_high),
        .i_held     (r_held),
        .i_len      (r_len),
        .i_par      (r_par),
        .i_pair_cnt (r_pair_cnt),
        .o_res      (calc_res),
        .o_pair_cnt (n_pair_cnt)
    );

    assign o_valid         = (r_cnt != '0);
    assign pop             = o_valid && i_ready;
    assign advance         = r_in_valid && ((r_cnt == '0) || ((r_cnt == t_cnt'(1)) && i_ready));
    assign o_ready         = !r_in_valid || advance;
    assign o_output_sample = r_buf[0];
    assign o_last_of_line  = r_last_line && (r_cnt == t_cnt'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= t_len'(1);
            r_par      <= 1'b0;
            r_pair_cnt <= '0;
            r_held     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINE_LENGTH: begin
                    r_len      <= i_cfg_data[LEN_BITS-1:0];
                    r_pair_cnt <= '0;
                end
                CFG_START_PARITY: begin
                    r_par      <= i_cfg_data[0];
                    r_pair_cnt <= '0;
                end
                default: begin
                    r_pair_cnt <= r_pair_cnt;
                end
            endcase
        end else if (advance) begin
            r_pair_cnt <= n_pair_cnt;
            r_held     <= calc_res.held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_low  <= i_low_coef;
            r_in_high <= i_high_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (advance) begin
            r_cnt <= calc_res.count;
        end else if (pop) begin
            r_cnt <= r_cnt - t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_buf       <= calc_res.samples;
            r_last_line <= calc_res.last_line;
        end else if (pop) begin
            for (int i = 0; i < NUM_SLOTS - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

endmodule
